/* hw/rtl/bbrm_pkg.sv */
// Shared types and constants of the bipartite buffer region manager.
// No dependencies; imported by the top level and by its checker.
package bbrm_pkg;

   localparam int KIND_W   = 2;
   localparam int LENGTH_W = 13;
   localparam int OFFSET_W = 12;

   typedef enum logic [KIND_W-1:0] {
      KIND_RESERVE  = 2'd0,
      KIND_COMMIT   = 2'd1,
      KIND_DECOMMIT = 2'd2,
      KIND_CLEAR    = 2'd3
   } kind_type;

endpackage

/* hw/rtl/bipartite_buffer_region_manager.sv */
// Region bookkeeping of a bipartite buffer: reserve, commit, decommit, clear.
// Depends on bbrm_pkg for the operation codes and field widths.
//
// One transaction is accepted per clock whenever start is high and busy is low
// (busy only follows reset). The request is captured in an input register, the
// region update is done by the logic behind it, and the result is registered and
// appears on the rsp_ ports, marked by rsp_valid for exactly one cycle. A new
// request may be accepted in every cycle, so the sustained rate is one transaction
// per clock; the limit is the single region-update path between the input
// register and the state and result registers. Results cannot be held off and
// must be taken in the cycle they are shown.
module bipartite_buffer_region_manager #(
   parameter int CAPACITY = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [bbrm_pkg::KIND_W-1:0]   req_kind,
   input  logic [bbrm_pkg::LENGTH_W-1:0] req_length,
   output logic                          rsp_valid,
   output logic [bbrm_pkg::OFFSET_W-1:0] rsp_grant_offset,
   output logic [bbrm_pkg::LENGTH_W-1:0] rsp_grant_length,
   output logic [bbrm_pkg::OFFSET_W-1:0] rsp_read_offset,
   output logic [bbrm_pkg::LENGTH_W-1:0] rsp_read_length,
   output logic [bbrm_pkg::LENGTH_W-1:0] rsp_used_bytes,
   output logic [bbrm_pkg::LENGTH_W-1:0] rsp_free_bytes
);
   import bbrm_pkg::*;

   localparam int W  = $clog2(CAPACITY + 1);
   localparam int CW = (W > LENGTH_W) ? W : LENGTH_W;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   function automatic logic [CW-1:0] min_c(input logic [CW-1:0] x, input logic [CW-1:0] y);
      return (x < y) ? x : y;
   endfunction

   function automatic logic [CW-1:0] sub_sat(input logic [CW-1:0] x, input logic [CW-1:0] y);
      return (x > y) ? (x - y) : '0;
   endfunction

   // Input register.
   logic                in_valid_ff;
   kind_type            in_kind_ff;
   logic [LENGTH_W-1:0] in_length_ff;

   // Region state.
   logic [W-1:0] a_start_ff, a_start_in;
   logic [W-1:0] a_end_ff, a_end_in;
   logic [W-1:0] b_start_ff, b_start_in;
   logic [W-1:0] b_end_ff, b_end_in;
   logic         writing_b_ff, writing_b_in;
   logic [W-1:0] res_len_ff, res_len_in;

   // Result register.
   logic                rsp_valid_ff;
   logic [OFFSET_W-1:0] grant_offset_ff, grant_offset_in;
   logic [LENGTH_W-1:0] grant_length_ff, grant_length_in;
   logic [OFFSET_W-1:0] read_offset_ff, read_offset_in;
   logic [LENGTH_W-1:0] read_length_ff, read_length_in;
   logic [LENGTH_W-1:0] used_ff, used_in;
   logic [LENGTH_W-1:0] free_ff, free_in;

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
      in_kind_ff   <= kind_type'(req_kind);
      in_length_ff <= req_length;
   end

   always_comb begin
      logic [CW-1:0] len, as, ae, bs, be, rl, room, grant, wstart, n, r_off, r_len;
      logic [CW:0]   used_w, free_w;

      len    = CW'(in_length_ff);
      as     = CW'(a_start_ff);
      ae     = CW'(a_end_ff);
      bs     = CW'(b_start_ff);
      be     = CW'(b_end_ff);
      rl     = CW'(res_len_ff);
      writing_b_in = writing_b_ff;
      grant  = '0;
      wstart = '0;
      room   = '0;
      n      = '0;

      case (in_kind_ff)
         KIND_RESERVE: begin
            if (writing_b_ff) begin
               room   = sub_sat(as, be);
               grant  = min_c(len, room);
               wstart = be;
            end else begin
               room = sub_sat(CAP_C, ae);
               if (room >= len || room >= as) begin
                  grant  = min_c(len, room);
                  wstart = ae;
               end else begin
                  writing_b_in = 1'b1;
                  grant        = min_c(len, as);
                  wstart       = '0;
               end
            end
            if (grant == '0) begin
               wstart = '0;
            end
            rl = grant;
         end
         KIND_COMMIT: begin
            n = min_c(len, rl);
            if (writing_b_ff) begin
               be = be + n;
            end else begin
               ae = ae + n;
            end
            rl = '0;
         end
         KIND_DECOMMIT: begin
            if (as < ae) begin
               as = as + min_c(len, ae - as);
               if (as == ae) begin
                  as = '0;
                  ae = '0;
                  if (be != '0) begin
                     as = bs;
                     ae = be;
                     bs = '0;
                     be = '0;
                  end
                  writing_b_in = 1'b0;
               end
            end else if (bs < be) begin
               bs = bs + min_c(len, be - bs);
               if (bs == be) begin
                  bs = '0;
                  be = '0;
                  writing_b_in = 1'b0;
               end
            end
         end
         default: begin
            // Clear returns every region, the mode and the reservation to zero.
            as = '0;
            ae = '0;
            bs = '0;
            be = '0;
            rl = '0;
            writing_b_in = 1'b0;
         end
      endcase

      if (as < ae) begin
         r_off = as;
         r_len = ae - as;
      end else if (bs < be) begin
         r_off = bs;
         r_len = be - bs;
      end else begin
         r_off = '0;
         r_len = '0;
      end
      used_w = {1'b0, sub_sat(ae, as)} + {1'b0, sub_sat(be, bs)};
      if (writing_b_in) begin
         free_w = {1'b0, sub_sat(as, be)};
      end else begin
         free_w = {1'b0, sub_sat(CAP_C, ae)} + {1'b0, as};
      end

      a_start_in = as[W-1:0];
      a_end_in   = ae[W-1:0];
      b_start_in = bs[W-1:0];
      b_end_in   = be[W-1:0];
      res_len_in = rl[W-1:0];

      grant_offset_in = wstart[OFFSET_W-1:0];
      grant_length_in = grant[LENGTH_W-1:0];
      read_offset_in  = r_off[OFFSET_W-1:0];
      read_length_in  = r_len[LENGTH_W-1:0];
      used_in         = used_w[LENGTH_W-1:0];
      free_in         = free_w[LENGTH_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_start_ff   <= '0;
         a_end_ff     <= '0;
         b_start_ff   <= '0;
         b_end_ff     <= '0;
         writing_b_ff <= 1'b0;
         res_len_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            a_start_ff   <= a_start_in;
            a_end_ff     <= a_end_in;
            b_start_ff   <= b_start_in;
            b_end_ff     <= b_end_in;
            writing_b_ff <= writing_b_in;
            res_len_ff   <= res_len_in;
         end
      end
      if (in_valid_ff) begin
         grant_offset_ff <= grant_offset_in;
         grant_length_ff <= grant_length_in;
         read_offset_ff  <= read_offset_in;
         read_length_ff  <= read_length_in;
         used_ff         <= used_in;
         free_ff         <= free_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_grant_offset = grant_offset_ff;
   assign rsp_grant_length = grant_length_ff;
   assign rsp_read_offset  = read_offset_ff;
   assign rsp_read_length  = read_length_ff;
   assign rsp_used_bytes   = used_ff;
   assign rsp_free_bytes   = free_ff;

endmodule

/* hw/rtl/bbrm_checker.sv */
// Port-level checks of the bipartite buffer region manager, bound to its top level.
// Depends on bbrm_pkg for the operation codes and field widths.
module bbrm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [bbrm_pkg::KIND_W-1:0]   req_kind,
   input logic [bbrm_pkg::LENGTH_W-1:0] req_length,
   input logic                          rsp_valid,
   input logic [bbrm_pkg::OFFSET_W-1:0] rsp_grant_offset,
   input logic [bbrm_pkg::LENGTH_W-1:0] rsp_grant_length,
   input logic [bbrm_pkg::OFFSET_W-1:0] rsp_read_offset,
   input logic [bbrm_pkg::LENGTH_W-1:0] rsp_read_length,
   input logic [bbrm_pkg::LENGTH_W-1:0] rsp_used_bytes,
   input logic [bbrm_pkg::LENGTH_W-1:0] rsp_free_bytes
);
   import bbrm_pkg::*;

   // Every accepted transaction yields exactly one result strobe.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(reset, 2)) |->
         (rsp_valid == $past(start && !busy, 2)))
      else $error("result strobe does not match accepted transactions");

   // A clear leaves nothing to read.
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(start && !busy && (req_kind == KIND_CLEAR), 2)) |->
         (rsp_used_bytes == '0 && rsp_read_length == '0 && rsp_read_offset == '0))
      else $error("clear left data in the buffer");

   // Only a reserve can grant a window.
   a_grant_kind: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(start && !busy && (req_kind != KIND_RESERVE), 2)) |->
         (rsp_grant_length == '0 && rsp_grant_offset == '0))
      else $error("grant reported for a transaction that is not a reserve");

   // The contiguous read window never exceeds the committed data.
   a_read_within_used: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_read_length <= rsp_used_bytes))
      else $error("read window larger than used byte count");

   // An empty read window starts at offset zero.
   a_empty_window: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_read_length == '0) |-> (rsp_read_offset == '0))
      else $error("empty read window with nonzero offset");

endmodule

bind bipartite_buffer_region_manager bbrm_checker u_bbrm_checker (.*);
